### src/fermion_occupation_bitstring_unit_core_defines.svh
// Assertion macros used by the core RTL file.
`ifndef FERMION_OCCUPATION_BITSTRING_UNIT_CORE_DEFINES_SVH
`define FERMION_OCCUPATION_BITSTRING_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FOBU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fobu: assertion failed");

// Next-cycle implication, checked outside reset.
`define FOBU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fobu: assertion failed");

`endif

### src/fobu_pkg.sv
package fobu_pkg;

    localparam int VEC_W    = 64;
    localparam int ORB_W    = 6;
    localparam int CNT_W    = 7;
    localparam int ACTION_W = 3;
    localparam int ERR_W    = 2;
    localparam int SIGN_W   = 2;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] MAX_ORBITALS = 7'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD      = 3'd0,
        ACT_ANNIHILATE = 3'd1,
        ACT_CREATE    = 3'd2,
        ACT_QUERY     = 3'd3,
        ACT_LIST_OCC  = 3'd4,
        ACT_COUNT_DIFF = 3'd5,
        ACT_LIST_DIFF = 3'd6
    } t_action;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_MISMATCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ORBITALS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_LIST = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

endpackage

### src/fermion_occupation_bitstring_unit_core.sv
// Holds one 64-orbital occupation string and runs one action per input transaction through a
// single shift-and-count unit that walks the working word one bit per cycle, except while a
// listed result waits on i_stall. The block is busy (o_stall high) from acceptance until the
// transaction's last result has been loaded into the output register, so one transaction
// never overlaps the next. Query, out-of-range, failed create/annihilate, unused actions and
// empty lists go straight to the emit state. Load, count and successful create/annihilate
// first shift the scanned word (the loaded string, the difference word, or the occupied
// orbitals below the target) down to zero in the scan state. Listing actions walk the listed
// word up to its highest listed position. Every result can wait on i_stall.
module fermion_occupation_bitstring_unit_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [fobu_pkg::ACTION_W-1:0]     i_action,
    input  logic [fobu_pkg::ORB_W-1:0]        i_orbital,
    input  logic [fobu_pkg::VEC_W-1:0]        i_vector_in,
    input  logic signed [fobu_pkg::SIGN_W-1:0] i_sign_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_ok,
    output logic [fobu_pkg::ERR_W-1:0]        o_error,
    output logic signed [fobu_pkg::SIGN_W-1:0] o_sign_out,
    output logic [fobu_pkg::ORB_W-1:0]        o_position,
    output logic [fobu_pkg::CNT_W-1:0]        o_count,
    output logic [fobu_pkg::VEC_W-1:0]        o_vector_out,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [fobu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fobu_pkg::CFG_W-1:0]        i_cfg_data
);
    import fobu_pkg::*;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_num_orb, r_expected;
    logic [VEC_W-1:0]   r_string, n_string;
    logic [VEC_W-1:0]   r_work, n_work;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [ORB_W-1:0]   r_pos, n_pos;
    t_action            r_act, n_act;
    logic [SIGN_W-1:0]  r_sign, n_sign;
    logic               r_res_ok, n_res_ok;
    logic [ERR_W-1:0]   r_res_err, n_res_err;

    logic               r_o_valid, n_o_valid;
    logic               r_o_ok, n_o_ok;
    logic [ERR_W-1:0]   r_o_err, n_o_err;
    logic [SIGN_W-1:0]  r_o_sign, n_o_sign;
    logic [ORB_W-1:0]   r_o_pos, n_o_pos;
    logic [CNT_W-1:0]   r_o_cnt, n_o_cnt;
    logic [VEC_W-1:0]   r_o_vec, n_o_vec;
    logic               r_o_last, n_o_last;

    logic               w_accept;
    logic               w_out_free;
    logic [CNT_W-1:0]   w_eff_orb;
    logic               w_in_range;
    logic [VEC_W-1:0]   w_bit;
    logic [VEC_W-1:0]   w_below;
    logic               w_occupied;
    logic [VEC_W-1:0]   w_list_word;
    logic [VEC_W-1:0]   w_shifted;
    logic               w_load_ok;
    logic [SIGN_W-1:0]  w_neg_sign;

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_o_valid || !i_stall;

    assign w_eff_orb   = (r_num_orb > MAX_ORBITALS) ? MAX_ORBITALS : r_num_orb;
    assign w_in_range  = ({1'b0, i_orbital} < w_eff_orb);
    assign w_bit       = {{(VEC_W-1){1'b0}}, 1'b1} << i_orbital;
    assign w_below     = w_bit - {{(VEC_W-1){1'b0}}, 1'b1};
    assign w_occupied  = |(r_string & w_bit);
    assign w_list_word = (t_action'(i_action) == ACT_LIST_DIFF) ? (r_string & ~i_vector_in)
                                                                : r_string;
    assign w_shifted   = r_work >> 1;
    assign w_load_ok   = (r_cnt == r_expected);
    assign w_neg_sign  = ~r_sign + {{(SIGN_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_state   = r_state;
        n_string  = r_string;
        n_work    = r_work;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_act     = r_act;
        n_sign    = r_sign;
        n_res_ok  = r_res_ok;
        n_res_err = r_res_err;
        n_o_valid = r_o_valid && i_stall;
        n_o_ok    = r_o_ok;
        n_o_err   = r_o_err;
        n_o_sign  = r_o_sign;
        n_o_pos   = r_o_pos;
        n_o_cnt   = r_o_cnt;
        n_o_vec   = r_o_vec;
        n_o_last  = r_o_last;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_act     = t_action'(i_action);
                    n_sign    = i_sign_in;
                    n_cnt     = '0;
                    n_pos     = '0;
                    n_res_ok  = 1'b0;
                    n_res_err = ERR_NONE;
                    n_state   = ST_EMIT;
                    unique case (t_action'(i_action))
                        ACT_LOAD: begin
                            n_string = i_vector_in;
                            n_work   = i_vector_in;
                            n_state  = ST_SCAN;
                        end
                        ACT_ANNIHILATE, ACT_CREATE: begin
                            if (!w_in_range) begin
                                n_res_err = ERR_RANGE;
                            end else if (w_occupied ==
                                         (t_action'(i_action) == ACT_ANNIHILATE)) begin
                                n_string = r_string ^ w_bit;
                                n_work   = r_string & w_below;
                                n_res_ok = 1'b1;
                                n_state  = ST_SCAN;
                            end
                        end
                        ACT_QUERY: begin
                            if (!w_in_range) begin
                                n_res_err = ERR_RANGE;
                            end else begin
                                n_res_ok = w_occupied;
                            end
                        end
                        ACT_COUNT_DIFF: begin
                            n_work  = r_string ^ i_vector_in;
                            n_state = ST_SCAN;
                        end
                        ACT_LIST_OCC, ACT_LIST_DIFF: begin
                            n_work = w_list_word;
                            if (w_list_word != '0) begin
                                n_state = ST_LIST;
                            end
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_work == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_work = w_shifted;
                    n_cnt  = r_cnt + {{(CNT_W-1){1'b0}}, r_work[0]};
                end
            end
            ST_LIST: begin
                if (!r_work[0]) begin
                    n_work = w_shifted;
                    n_pos  = r_pos + {{(ORB_W-1){1'b0}}, 1'b1};
                end else if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_ok    = 1'b1;
                    n_o_err   = ERR_NONE;
                    n_o_sign  = r_sign;
                    n_o_pos   = r_pos;
                    n_o_cnt   = '0;
                    n_o_vec   = r_string;
                    n_o_last  = (w_shifted == '0);
                    n_work    = w_shifted;
                    n_pos     = r_pos + {{(ORB_W-1){1'b0}}, 1'b1};
                    if (w_shifted == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_pos   = '0;
                    n_o_cnt   = '0;
                    n_o_vec   = r_string;
                    n_o_last  = 1'b1;
                    n_o_sign  = r_sign;
                    n_o_ok    = r_res_ok;
                    n_o_err   = r_res_err;
                    unique case (r_act)
                        ACT_LOAD: begin
                            n_o_ok  = w_load_ok;
                            n_o_err = w_load_ok ? ERR_NONE : ERR_MISMATCH;
                        end
                        ACT_ANNIHILATE, ACT_CREATE: begin
                            if (r_res_ok && r_cnt[0]) begin
                                n_o_sign = w_neg_sign;
                            end
                        end
                        ACT_COUNT_DIFF: begin
                            n_o_ok  = 1'b1;
                            n_o_cnt = r_cnt;
                        end
                        default: begin
                            n_o_ok = r_res_ok;
                        end
                    endcase
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_string   <= '0;
            r_o_valid  <= 1'b0;
            r_num_orb  <= MAX_ORBITALS;
            r_expected <= '0;
        end else begin
            r_state   <= n_state;
            r_string  <= n_string;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_NUM_ORBITALS) begin
                    r_num_orb <= i_cfg_data;
                end else if (i_cfg_index == CFG_EXPECTED) begin
                    r_expected <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work    <= n_work;
        r_cnt     <= n_cnt;
        r_pos     <= n_pos;
        r_act     <= n_act;
        r_sign    <= n_sign;
        r_res_ok  <= n_res_ok;
        r_res_err <= n_res_err;
        r_o_ok    <= n_o_ok;
        r_o_err   <= n_o_err;
        r_o_sign  <= n_o_sign;
        r_o_pos   <= n_o_pos;
        r_o_cnt   <= n_o_cnt;
        r_o_vec   <= n_o_vec;
        r_o_last  <= n_o_last;
    end

    assign o_valid      = r_o_valid;
    assign o_ok         = r_o_ok;
    assign o_error      = r_o_err;
    assign o_sign_out   = r_o_sign;
    assign o_position   = r_o_pos;
    assign o_count      = r_o_cnt;
    assign o_vector_out = r_o_vec;
    assign o_last       = r_o_last;

`include "fermion_occupation_bitstring_unit_core_defines.svh"

    `FOBU_ASSERT_NEXT(a_accept_starts_work, i_valid && !o_stall, r_state != ST_IDLE)
    `FOBU_ASSERT_NOW(a_open_list_in_progress, r_o_valid && !r_o_last, r_state == ST_LIST)
    `FOBU_ASSERT_NOW(a_position_only_listed, r_o_valid && (r_o_pos != '0), r_o_ok)

endmodule
